### src/ctc_greedy_topk_decoder_core_defines.svh
// assertion macros used by the decoder rtl
`ifndef CTC_GREEDY_TOPK_DECODER_CORE_DEFINES_SVH
`define CTC_GREEDY_TOPK_DECODER_CORE_DEFINES_SVH

// same-cycle implication, checked outside reset
`define CTG_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define CTG_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

### src/ctg_pkg.sv
// shared constants and types of the ctc greedy top-k decoder
`timescale 1ns / 1ps
`default_nettype none
package ctg_pkg;
    localparam int NUM_CLASSES = 128;
    localparam int TOPK_MAX    = 4;
    localparam int MAX_STEPS   = 64;

    localparam int CLASS_W = 7;
    localparam int SCORE_W = 16;
    localparam int POS_W   = 7;
    localparam int K_W     = 3;
    localparam int SUM_W   = 22;
    localparam int CFG_W   = 16;
    localparam int CFG_IDX_W = 2;
    localparam int PEND_W  = TOPK_MAX + 1;
    localparam int SEL_W   = $clog2(PEND_W);
    localparam int CELL_W  = (TOPK_MAX > 1) ? $clog2(TOPK_MAX) : 1;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_TOPK_COUNT   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BLANK_CLASS  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_REPLACE_THR  = 2'd2;

    // result kinds
    localparam logic [1:0] KIND_CHAR    = 2'd0;
    localparam logic [1:0] KIND_REPLACE = 2'd1;
    localparam logic [1:0] KIND_SUMMARY = 2'd2;

    typedef struct packed {
        logic               valid;
        logic [CLASS_W-1:0] idx;
        logic [SCORE_W-1:0] score;
    } ctg_entry_t;
endpackage
`default_nettype wire

### src/ctg_cell.sv
// one rank cell of the sorted top-k chain
`timescale 1ns / 1ps
`default_nettype none
module ctg_cell
    import ctg_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       clear,
    input  wire logic       ins,
    input  wire ctg_entry_t new_ent,
    input  wire ctg_entry_t prev_ent,
    input  wire logic       prev_take,
    output ctg_entry_t      ent,
    output logic            take
);
    ctg_entry_t ent_reg, ent_next;

    // lower index wins ties, so an equal score keeps its place
    assign take = ins && !(ent_reg.valid && (ent_reg.score >= new_ent.score));
    assign ent  = ent_reg;

    always_comb begin
        ent_next = ent_reg;
        if (clear) begin
            ent_next.valid = 1'b0;
        end else if (take) begin
            ent_next = prev_take ? prev_ent : new_ent;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ent_reg <= '0;
        end else begin
            ent_reg <= ent_next;
        end
    end
endmodule
`default_nettype wire

### src/ctg_div.sv
// iterative restoring divider for the mean confidence
`timescale 1ns / 1ps
`default_nettype none
module ctg_div
    import ctg_pkg::*;
(
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               start,
    input  wire logic [SUM_W-1:0]   dividend,
    input  wire logic [POS_W-1:0]   divisor,
    output logic                    busy,
    output logic [SCORE_W-1:0]      quotient
);
    localparam int CNT_W = $clog2(SUM_W);

    logic               busy_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic [SUM_W-1:0]   dvd_reg;
    logic [POS_W-1:0]   rem_reg;
    logic [POS_W-1:0]   dvs_reg;
    logic [POS_W:0]     rem_sh;
    logic               qbit;

    assign rem_sh = {rem_reg, dvd_reg[SUM_W-1]};
    assign qbit   = (rem_sh >= {1'b0, dvs_reg});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (start) begin
            busy_reg <= 1'b1;
            cnt_reg  <= CNT_W'(SUM_W - 1);
            dvd_reg  <= dividend;
            dvs_reg  <= divisor;
            rem_reg  <= '0;
        end else if (busy_reg) begin
            // one quotient bit a cycle, shifted into the dividend register
            rem_reg  <= qbit ? POS_W'(rem_sh - {1'b0, dvs_reg}) : rem_sh[POS_W-1:0];
            dvd_reg  <= {dvd_reg[SUM_W-2:0], qbit};
            cnt_reg  <= cnt_reg - 1'b1;
            busy_reg <= (cnt_reg != '0);
        end
    end

    assign busy     = busy_reg;
    assign quotient = dvd_reg[SCORE_W-1:0];
endmodule
`default_nettype wire

### src/ctc_greedy_topk_decoder_core.sv
// top level of the ctc greedy top-k decoder
`timescale 1ns / 1ps
`default_nettype none
// Greedy CTC decoder with top-k replacement candidates. Class scores arrive one per
// transfer, in class order; each score is ranked into a chain of TOPK_MAX cells in the
// cycle it is taken. The transfer that ends a step (s_tuser) or a sequence (s_tlast) also
// carries a score; a decision state follows, then one result per cycle while the output is
// free (character, then replacements), and a closing state that clears the chain.
// A sequence end also starts the restoring divider for the mean confidence in the decision
// state; the characters leave while it runs and the summary waits for it.
// Results leave through a single output register; the input waits while a step's
// results are being sent.
module ctc_greedy_topk_decoder_core
    import ctg_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    // configuration writes
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]     cfg_wdata,
    // score stream
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [15:0]          s_tdata,   // score[15:0]
    input  wire logic                 s_tuser,   // step_end
    input  wire logic                 s_tlast,   // sequence_end
    // result stream
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic [55:0]               m_tdata,   // class_id[6:0], probability[22:7],
                                                 // position[29:23], char_count[36:30],
                                                 // mean_confidence[52:37], zero pad
    output logic [1:0]                m_tuser,   // kind[1:0]
    output logic                      m_tlast    // last
);
`include "ctc_greedy_topk_decoder_core_defines.svh"

    typedef enum logic [1:0] {ST_IDLE, ST_DECIDE, ST_EMIT} state_t;

    state_t               state_reg;
    // configuration
    logic [K_W-1:0]       topk_reg;
    logic [CLASS_W-1:0]   blank_reg;
    logic [SCORE_W-1:0]   thr_reg;
    // decoder state
    logic [CLASS_W-1:0]   class_cnt_reg;
    logic [CLASS_W-1:0]   prev_top_reg;
    logic                 first_reg;
    logic [POS_W-1:0]     char_pos_reg;
    logic [SUM_W-1:0]     conf_sum_reg;
    logic                 seq_end_reg;
    logic [PEND_W-1:0]    pend_reg;
    logic [POS_W-1:0]     emit_pos_reg;
    logic [POS_W-1:0]     sum_cnt_reg;
    // output register
    logic                 m_tvalid_reg;
    logic [1:0]           kind_reg;
    logic [CLASS_W-1:0]   cls_reg;
    logic [SCORE_W-1:0]   prob_reg;
    logic [POS_W-1:0]     pos_reg;
    logic [POS_W-1:0]     cnt_reg;
    logic [SCORE_W-1:0]   mean_reg;
    logic                 last_reg;

    logic                 s_fire;
    logic                 cell_clear;
    ctg_entry_t           new_ent;
    ctg_entry_t           ent  [TOPK_MAX];
    logic                 take [TOPK_MAX];

    assign s_tready = (state_reg == ST_IDLE);
    assign s_fire   = s_tvalid && s_tready;

    assign new_ent.valid = 1'b1;
    assign new_ent.idx   = class_cnt_reg;
    assign new_ent.score = s_tdata[SCORE_W-1:0];

    // sorted chain: cell 0 holds the best score; cells at and below the insert point shift down
    for (genvar gi = 0; gi < TOPK_MAX; gi++) begin : g_cell
        ctg_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .clear     (cell_clear),
            .ins       (s_fire),
            .new_ent   (new_ent),
            .prev_ent  ((gi == 0) ? ctg_entry_t'('0) : ent[(gi == 0) ? 0 : gi-1]),
            .prev_take ((gi == 0) ? 1'b0 : take[(gi == 0) ? 0 : gi-1]),
            .ent       (ent[gi]),
            .take      (take[gi])
        );
    end

    // step end decision, evaluated from the settled chain
    logic [K_W-1:0]       filled;
    logic [K_W-1:0]       k_clamp;
    logic [K_W-1:0]       k_eff;
    logic                 drop;
    logic [SCORE_W-1:0]   top_prob;
    logic [PEND_W-1:0]    pend_new;
    logic [POS_W-1:0]     pos_after;
    logic [SUM_W-1:0]     sum_after;

    always_comb begin
        filled = '0;
        for (int i = 0; i < TOPK_MAX; i++) begin
            filled = filled + K_W'(ent[i].valid);
        end
        if (topk_reg == '0) begin
            k_clamp = K_W'(1);
        end else if (topk_reg > K_W'(TOPK_MAX)) begin
            k_clamp = K_W'(TOPK_MAX);
        end else begin
            k_clamp = topk_reg;
        end
        k_eff = (k_clamp > filled) ? filled : k_clamp;
        drop  = (k_eff == '0) || (ent[0].idx == blank_reg)
             || (!first_reg && (ent[0].idx == prev_top_reg))
             || (char_pos_reg >= POS_W'(MAX_STEPS));
        // zero score counts as full confidence
        top_prob = (ent[0].score == '0) ? {SCORE_W{1'b1}} : ent[0].score;
        pend_new = '0;
        pend_new[0] = !drop;
        for (int i = 1; i < TOPK_MAX; i++) begin
            pend_new[i] = !drop && (K_W'(i) < k_eff) && (ent[i].idx != blank_reg)
                       && (ent[i].score >= thr_reg);
        end
        pend_new[TOPK_MAX] = seq_end_reg;
        pos_after = char_pos_reg + POS_W'(!drop);
        sum_after = drop ? conf_sum_reg : conf_sum_reg + SUM_W'(top_prob);
    end

    // mean divider, round half up
    logic                 div_start;
    logic                 div_busy;
    logic [SCORE_W-1:0]   div_q;

    assign div_start = (state_reg == ST_DECIDE) && seq_end_reg;

    ctg_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (sum_after + SUM_W'(pos_after >> 1)),
        .divisor  (pos_after),
        .busy     (div_busy),
        .quotient (div_q)
    );

    // pick the lowest pending result
    logic [SEL_W-1:0]     sel;
    logic                 sel_found;
    logic [PEND_W-1:0]    pend_rest;
    logic                 out_free;
    logic                 emit_go;
    logic [CELL_W-1:0]    sel_cell;

    always_comb begin
        sel       = '0;
        sel_found = 1'b0;
        for (int i = 0; i < PEND_W; i++) begin
            if (!sel_found && pend_reg[i]) begin
                sel       = SEL_W'(i);
                sel_found = 1'b1;
            end
        end
        pend_rest      = pend_reg;
        pend_rest[sel] = 1'b0;
    end

    assign sel_cell   = sel[CELL_W-1:0];
    assign out_free   = !m_tvalid_reg || m_tready;
    assign emit_go    = (state_reg == ST_EMIT) && sel_found && out_free
                     && ((sel != SEL_W'(TOPK_MAX)) || !div_busy);
    assign cell_clear = (state_reg == ST_EMIT) && !sel_found;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            topk_reg      <= K_W'(4);
            blank_reg     <= '0;
            thr_reg       <= '0;
            class_cnt_reg <= '0;
            prev_top_reg  <= '0;
            first_reg     <= 1'b1;
            char_pos_reg  <= '0;
            conf_sum_reg  <= '0;
            seq_end_reg   <= 1'b0;
            pend_reg      <= '0;
            m_tvalid_reg  <= 1'b0;
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    REG_TOPK_COUNT:  topk_reg  <= cfg_wdata[K_W-1:0];
                    REG_BLANK_CLASS: blank_reg <= cfg_wdata[CLASS_W-1:0];
                    REG_REPLACE_THR: thr_reg   <= cfg_wdata[SCORE_W-1:0];
                    default: ;
                endcase
            end
            // a new result in the same cycle keeps the register full
            if (m_tvalid_reg && m_tready && !emit_go) begin
                m_tvalid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (s_fire) begin
                        if (s_tuser || s_tlast) begin
                            class_cnt_reg <= '0;
                            seq_end_reg   <= s_tlast;
                            state_reg     <= ST_DECIDE;
                        end else begin
                            class_cnt_reg <= (class_cnt_reg == CLASS_W'(NUM_CLASSES - 1))
                                           ? '0 : class_cnt_reg + 1'b1;
                        end
                    end
                end
                ST_DECIDE: begin
                    pend_reg     <= pend_new;
                    emit_pos_reg <= char_pos_reg;
                    prev_top_reg <= ent[0].idx;
                    if (seq_end_reg) begin
                        sum_cnt_reg  <= pos_after;
                        char_pos_reg <= '0;
                        conf_sum_reg <= '0;
                        first_reg    <= 1'b1;
                    end else begin
                        char_pos_reg <= pos_after;
                        conf_sum_reg <= sum_after;
                        first_reg    <= 1'b0;
                    end
                    state_reg <= ST_EMIT;
                end
                ST_EMIT: begin
                    if (!sel_found) begin
                        state_reg <= ST_IDLE;
                    end else if (emit_go) begin
                        pend_reg     <= pend_rest;
                        m_tvalid_reg <= 1'b1;
                        last_reg     <= (pend_rest == '0);
                        if (sel == SEL_W'(TOPK_MAX)) begin
                            kind_reg <= KIND_SUMMARY;
                            cls_reg  <= '0;
                            prob_reg <= '0;
                            pos_reg  <= '0;
                            cnt_reg  <= sum_cnt_reg;
                            mean_reg <= (sum_cnt_reg == '0) ? '0 : div_q;
                        end else if (sel == '0) begin
                            kind_reg <= KIND_CHAR;
                            cls_reg  <= ent[0].idx;
                            prob_reg <= top_prob;
                            pos_reg  <= emit_pos_reg;
                            cnt_reg  <= '0;
                            mean_reg <= '0;
                        end else begin
                            kind_reg <= KIND_REPLACE;
                            cls_reg  <= ent[sel_cell].idx;
                            prob_reg <= ent[sel_cell].score;
                            pos_reg  <= emit_pos_reg;
                            cnt_reg  <= '0;
                            mean_reg <= '0;
                        end
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = kind_reg;
    assign m_tlast  = last_reg;
    assign m_tdata  = {3'b000, mean_reg, cnt_reg, pos_reg, prob_reg, cls_reg};

    // scores are only taken between steps
    `CTG_ASSERT_NOW(a_fire_idle, s_tvalid && s_tready, state_reg == ST_IDLE,
        "score taken outside idle")
    // an empty pending set returns to idle
    `CTG_ASSERT_NEXT(a_emit_done, state_reg == ST_EMIT && pend_reg == '0,
        state_reg == ST_IDLE, "emit stuck with nothing pending")
    // the summary never leaves while the divider runs
    `CTG_ASSERT_NOW(a_sum_div, emit_go && sel == SEL_W'(TOPK_MAX), !div_busy,
        "summary before mean ready")
    // character count stays within the sequence limit
    `CTG_ASSERT_NOW(a_pos_max, 1'b1, char_pos_reg <= POS_W'(MAX_STEPS),
        "character position out of range")
endmodule
`default_nettype wire

### tb/ctg_checker.sv
// result predictor and scoreboard for the ctc greedy top-k decoder
`timescale 1ns / 1ps
module ctg_checker
    import ctg_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_wdata,
    input  logic                 s_tvalid,
    input  logic                 s_tready,
    input  logic [15:0]          s_tdata,
    input  logic                 s_tuser,
    input  logic                 s_tlast,
    input  logic                 m_tvalid,
    input  logic                 m_tready,
    input  logic [55:0]          m_tdata,
    input  logic [1:0]           m_tuser,
    input  logic                 m_tlast,
    output int                   fail_count,
    output int                   pending_count,
    output int                   result_count
);
    typedef struct packed {
        logic [1:0]         kind;
        logic [CLASS_W-1:0] class_id;
        logic [SCORE_W-1:0] prob;
        logic [POS_W-1:0]   position;
        logic [POS_W-1:0]   char_count;
        logic [SCORE_W-1:0] mean_conf;
        logic               last;
    } decoded_t;

    decoded_t expected_q[$];

    logic [K_W-1:0]     topk_reg;
    logic [CLASS_W-1:0] blank_reg;
    logic [SCORE_W-1:0] thr_reg;
    logic [CLASS_W-1:0] class_cnt;
    logic [CLASS_W-1:0] rank_idx[TOPK_MAX];
    logic [SCORE_W-1:0] rank_score[TOPK_MAX];
    int                 rank_fill;
    logic [CLASS_W-1:0] prev_top;
    logic               first_step;
    int                 char_pos;
    int                 conf_sum;

    assign pending_count = expected_q.size();

    task automatic push_result(input logic [1:0] kind, input int cls, input int prob,
                               input int pos, input int cnt, input int mean);
        decoded_t r;
        r.kind = kind;
        r.class_id = cls[CLASS_W-1:0];
        r.prob = prob[SCORE_W-1:0];
        r.position = pos[POS_W-1:0];
        r.char_count = cnt[POS_W-1:0];
        r.mean_conf = mean[SCORE_W-1:0];
        r.last = 1'b0;
        expected_q = {expected_q, r};
    endtask

    // ranks one score, then resolves step and sequence ends
    task automatic decode_score(input logic [15:0] score, input logic s_end, input logic q_end);
        int p;
        int i;
        int k;
        int n0;
        int prob;
        logic [CLASS_W-1:0] top;
        logic drop;
        n0 = expected_q.size();
        p = 0;
        while (p < rank_fill && rank_score[p] >= score) p++;
        if (p < TOPK_MAX) begin
            i = (rank_fill < TOPK_MAX) ? rank_fill : TOPK_MAX - 1;
            while (i > p) begin
                rank_idx[i] = rank_idx[i-1];
                rank_score[i] = rank_score[i-1];
                i--;
            end
            rank_idx[p] = class_cnt;
            rank_score[p] = score;
            if (rank_fill < TOPK_MAX) rank_fill++;
        end
        class_cnt = class_cnt + 1'b1;
        if (s_end || q_end) begin
            k = topk_reg;
            top = rank_idx[0];
            if (k < 1) k = 1;
            if (k > TOPK_MAX) k = TOPK_MAX;
            if (k > rank_fill) k = rank_fill;
            drop = (k == 0) || top == blank_reg || (!first_step && top == prev_top)
                   || char_pos >= MAX_STEPS;
            if (!drop) begin
                prob = (rank_score[0] != 0) ? rank_score[0] : 65535;
                push_result(KIND_CHAR, top, prob, char_pos, 0, 0);
                conf_sum += prob;
                for (i = 1; i < k; i++)
                    if (rank_idx[i] != blank_reg && rank_score[i] >= thr_reg)
                        push_result(KIND_REPLACE, rank_idx[i], rank_score[i], char_pos, 0, 0);
                char_pos++;
            end
            prev_top = top;
            first_step = 1'b0;
            rank_fill = 0;
            class_cnt = '0;
        end
        if (q_end) begin
            push_result(KIND_SUMMARY, 0, 0, 0, char_pos,
                        (char_pos != 0) ? (conf_sum + char_pos / 2) / char_pos : 0);
            char_pos = 0;
            conf_sum = 0;
            first_step = 1'b1;
        end
        if (expected_q.size() > n0) expected_q[$].last = 1'b1;
    endtask

    always @(posedge aclk) begin
        decoded_t got;
        decoded_t want;
        if (!aresetn) begin
            topk_reg <= 3'd4;
            blank_reg <= '0;
            thr_reg <= '0;
            class_cnt = '0;
            rank_fill = 0;
            prev_top = '0;
            first_step = 1'b1;
            char_pos = 0;
            conf_sum = 0;
            for (int i = 0; i < TOPK_MAX; i++) begin
                rank_idx[i] = '0;
                rank_score[i] = '0;
            end
            fail_count <= 0;
            result_count <= 0;
            expected_q.delete();
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    REG_TOPK_COUNT:  topk_reg <= cfg_wdata[K_W-1:0];
                    REG_BLANK_CLASS: blank_reg <= cfg_wdata[CLASS_W-1:0];
                    REG_REPLACE_THR: thr_reg <= cfg_wdata[SCORE_W-1:0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready) decode_score(s_tdata, s_tuser, s_tlast);
            if (m_tvalid && m_tready) begin
                got.kind = m_tuser;
                got.class_id = m_tdata[6:0];
                got.prob = m_tdata[22:7];
                got.position = m_tdata[29:23];
                got.char_count = m_tdata[36:30];
                got.mean_conf = m_tdata[52:37];
                got.last = m_tlast;
                result_count <= result_count + 1;
                if (expected_q.size() == 0) begin
                    $error("unexpected result transfer kind %0d", got.kind);
                    fail_count <= fail_count + 1;
                end else begin
                    want = expected_q.pop_front();
                    if (got != want) begin
                        fail_count <= fail_count + 1;
                        if (got.kind != want.kind)
                            $error("kind exp %0d got %0d", want.kind, got.kind);
                        if (got.class_id != want.class_id)
                            $error("class_id exp %0d got %0d", want.class_id, got.class_id);
                        if (got.prob != want.prob)
                            $error("probability exp %0d got %0d", want.prob, got.prob);
                        if (got.position != want.position)
                            $error("position exp %0d got %0d", want.position, got.position);
                        if (got.char_count != want.char_count)
                            $error("char_count exp %0d got %0d", want.char_count,
                                   got.char_count);
                        if (got.mean_conf != want.mean_conf)
                            $error("mean_confidence exp %0d got %0d", want.mean_conf,
                                   got.mean_conf);
                        if (got.last != want.last)
                            $error("last exp %0d got %0d", want.last, got.last);
                    end
                end
            end
        end
    end
endmodule

### tb/tb_top.sv
// stimulus, clock and verdict for the ctc greedy top-k decoder testbench
`timescale 1ns / 1ps
module tb_top;
    import ctg_pkg::*;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0]     cfg_wdata = '0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [15:0]          s_tdata = '0;
    logic                 s_tuser = 1'b0;
    logic                 s_tlast = 1'b0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [55:0]          m_tdata;
    logic [1:0]           m_tuser;
    logic                 m_tlast;
    int                   fail_count;
    int                   pending_count;
    int                   result_count;
    int                   item_count = 0;
    int                   seq_count = 0;
    bit                   hold_off = 1'b0;   // long receiver stall requested
    bit                   no_idle = 1'b0;    // stretch without gaps on either side

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    ctc_greedy_topk_decoder_core dut (.*);

    ctg_checker checker_i (.*);

    // receiver: random gaps per transfer, plus one long hold-off on request
    initial begin
        int gap;
        m_tready = 1'b0;
        wait (aresetn);
        forever begin
            @(negedge aclk);
            if (hold_off) begin
                m_tready <= 1'b0;
                repeat (300) @(negedge aclk);
                hold_off = 1'b0;
            end
            gap = no_idle ? 0 : $urandom_range(0, 4);
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
            m_tready <= 1'b1;
            @(posedge aclk);
            while (!m_tvalid) @(posedge aclk);
        end
    end

    // one score transfer, gap drawn first; valid stays up for a following transfer
    task automatic send_score(input logic [15:0] score, input logic s_end, input logic q_end);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 4);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= score;
        s_tuser <= s_end;
        s_tlast <= q_end;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        @(negedge aclk);
        item_count++;
        if (q_end) seq_count++;
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value[CFG_W-1:0];
        @(negedge aclk);
        cfg_we <= 1'b0;
        @(negedge aclk);
    endtask

    // waits until every expected result has arrived and the block has settled
    task automatic drain;
        s_tvalid <= 1'b0;
        while (pending_count != 0) @(negedge aclk);
        repeat (40) @(negedge aclk);
    endtask

    // random score, biased toward extremes and ties
    function automatic logic [15:0] rand_score();
        case ($urandom_range(0, 5))
            0: return 16'h0000;
            1: return 16'hffff;
            2: return 16'(($urandom_range(0, 3)) * 16'h4000);
            default: return 16'($urandom);
        endcase
    endfunction

    // a well-formed step of n classes
    task automatic send_step(input int n, input logic q_end);
        for (int c = 0; c < n; c++)
            send_score(rand_score(), c == n - 1, q_end && c == n - 1);
    endtask

    initial begin
        int n;
        repeat (9) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // directed: reset settings, zero scores, repeats, blank top, short steps
        send_score(16'h0000, 1'b1, 1'b0);                  // zero score on the blank class, dropped
        send_score(16'h8000, 1'b0, 1'b0);
        send_score(16'h8000, 1'b0, 1'b0);                  // tie keeps lower index
        send_score(16'hffff, 1'b1, 1'b0);
        send_score(16'h1000, 1'b0, 1'b0);
        send_score(16'h0001, 1'b0, 1'b0);
        send_score(16'hfffe, 1'b1, 1'b0);
        send_score(16'h1234, 1'b0, 1'b0);
        send_score(16'h1234, 1'b0, 1'b0);
        send_score(16'hffff, 1'b1, 1'b0);                  // repeat of previous top
        send_score(16'h7fff, 1'b0, 1'b0);
        send_score(16'h00ff, 1'b0, 1'b1);                  // sequence end without step end
        send_score(16'h5555, 1'b1, 1'b1);                  // blank top, empty summary
        drain();
        write_reg(REG_TOPK_COUNT, 0);                      // acts as one
        write_reg(REG_BLANK_CLASS, 127);
        write_reg(REG_REPLACE_THR, 16'hffff);
        send_score(16'haaaa, 1'b0, 1'b0);
        send_score(16'hffff, 1'b1, 1'b0);
        drain();
        write_reg(REG_TOPK_COUNT, 7);                      // above the top-k size
        write_reg(REG_BLANK_CLASS, 2);
        write_reg(REG_REPLACE_THR, 0);
        send_step(6, 1'b0);
        send_step(3, 1'b1);
        drain();

        // character limit with alternating tops, no idling, and a long receiver
        // hold-off while scores keep coming
        write_reg(REG_BLANK_CLASS, 127);
        hold_off = 1'b1;
        no_idle = 1'b1;
        for (int s = 0; s < 65; s++) begin
            if (s % 2 == 0) begin
                send_score(16'h1000 + 16'(s), 1'b1, s == 64);
            end else begin
                send_score(16'h1000, 1'b0, 1'b0);
                send_score(16'h2000 + 16'(s), 1'b1, 1'b0);
            end
        end
        no_idle = 1'b0;
        drain();

        // class counter wrap: one step longer than the class range
        for (int c = 0; c < 129; c++) send_score(16'(c), c == 128, c == 128);
        drain();

        // random phases with different settings
        for (int ph = 0; ph < 2; ph++) begin
            write_reg(REG_TOPK_COUNT, $urandom_range(1, 4));
            write_reg(REG_BLANK_CLASS, $urandom_range(0, 5));
            write_reg(REG_REPLACE_THR, (ph == 1) ? 65535 : $urandom_range(0, 65535));
            repeat ($urandom_range(1, 2)) begin
                n = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 12)
                                                 : $urandom_range(1, 6);
                send_step(n, 1'b0);
            end
            send_step($urandom_range(1, 5), 1'b1);
            if ($urandom_range(0, 3) == 0) send_score(rand_score(), 1'b0, 1'b0);
            drain();                                       // sender waits for all results
        end

        $display("run covered %0d score transfers in %0d sequences, %0d results checked",
                 item_count, seq_count, result_count);
        if (fail_count == 0) begin
            $display("tb_top passed");
        end else begin
            $display("tb_top failed");
        end
        $finish;
    end

    // watchdog
    initial begin
        #4000000;
        $display("tb_top failed");
        $finish;
    end
endmodule
